>>> hw/rtl/adaptive_noise_floor_voice_gate_assert.svh
// Assertion macros used by the voice gate datapath.
`ifndef ADAPTIVE_NOISE_FLOOR_VOICE_GATE_ASSERT_SVH
`define ADAPTIVE_NOISE_FLOOR_VOICE_GATE_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define ANFVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ANFVG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ANFVG_ASSERT(lbl, prop, msg)
`define ANFVG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/anfvg_pkg.sv
// Shared constants and controller/datapath interface types for the voice gate.
package anfvg_pkg;

  // Ring depth and energy width.
  localparam int WINDOW      = 32;
  localparam int ENERGY_BITS = 32;
  localparam int IDX_W       = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);

  // Port widths.
  localparam int IN_E_W   = 32;
  localparam int VOTES_W  = 3;
  localparam int CFG_W    = 32;
  localparam int FLOOR_W  = 40;
  localparam int FRAC_W   = 8;

  // Smoothing weights in 1/256 units.
  localparam int OLD_WEIGHT = 179;
  localparam int NEW_WEIGHT = 77;
  localparam int WEIGHT_W   = 8;
  localparam int ROUND_HALF = 128;

  // Arithmetic widths.
  localparam int PROD_W  = FLOOR_W + WEIGHT_W;
  localparam int MNEW_W  = ENERGY_BITS + 7;
  localparam int SUM_W   = ((PROD_W - FRAC_W > MNEW_W) ? PROD_W - FRAC_W : MNEW_W) + 1;
  localparam int CMP_W   = (FLOOR_W + 1 > ENERGY_BITS + FRAC_W) ? FLOOR_W + 1
                                                                : ENERGY_BITS + FRAC_W;

  // Smallest vote count that allows a voiced decision.
  localparam logic [VOTES_W-1:0] VOTE_MIN = VOTES_W'(2);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;       // capture the accepted item
    logic ring_wr;   // store energy in the ring, bump slot and, until full, fill count
    logic rd_en;     // read one ring entry for the minimum scan
    logic mul;       // form the two weighted products
    logic upd;       // update the noise floor
    logic out_load;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // current read is the last filled entry
    logic out_free;   // result register can take a new item
  } sts_t;

endpackage

>>> hw/rtl/adaptive_noise_floor_voice_gate.sv
// Top level of the adaptive noise floor voice gate.
//
// Usage: each input transfer carries one frame energy and the upstream speech
// vote count. The block stores the energy in a ring of the last 32 frames,
// scans the ring for the minimum, smooths its noise floor toward that minimum
// and returns one result per frame: the voice flag and the updated floor with
// eight fraction bits. The cfg channel writes the minimum threshold; it is
// always ready and should be written only while no frame is in flight.
// A frame passes the write, scan, drain, multiply, update and done states
// before its result is loaded; the ring scan, one read per cycle from a
// memory with one read port, grows with the fill count. A new frame is taken
// in the cycle after the previous result is loaded, so frames do not overlap.
// Reset (synchronous, active low) empties the ring, clears the floor and the
// threshold register, and drops out_valid. When the receiver stalls, the
// result holds steady in the output register; the next frame is still taken
// and processed, and waits for the register to free up before loading.
module adaptive_noise_floor_voice_gate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [anfvg_pkg::IN_E_W-1:0]         in_frame_energy,
  input  logic [anfvg_pkg::VOTES_W-1:0]        in_speech_votes,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_voice,
  output logic [anfvg_pkg::FLOOR_W-1:0]        out_noise_level,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [anfvg_pkg::CFG_W-1:0]          cfg_data
);

  anfvg_pkg::cmd_t cmd;
  anfvg_pkg::sts_t sts;

  // The threshold register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Controller.
  anfvg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  anfvg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_frame_energy (in_frame_energy),
    .in_speech_votes (in_speech_votes),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_voice       (out_voice),
    .out_noise_level (out_noise_level)
  );

endmodule

>>> hw/rtl/anfvg_ctrl.sv
// Controller state machine sequencing one frame through the datapath.
module anfvg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  anfvg_pkg::sts_t    sts,
  output anfvg_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Input is taken only between frames.
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.ring_wr = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/anfvg_dp.sv
// Datapath: energy ring, minimum scan, floor smoothing, threshold and result register.
`include "adaptive_noise_floor_voice_gate_assert.svh"
module anfvg_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  anfvg_pkg::cmd_t                      cmd,
  output anfvg_pkg::sts_t                      sts,
  input  logic [anfvg_pkg::IN_E_W-1:0]         in_frame_energy,
  input  logic [anfvg_pkg::VOTES_W-1:0]        in_speech_votes,
  input  logic                                 cfg_valid,
  input  logic [anfvg_pkg::CFG_W-1:0]          cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_voice,
  output logic [anfvg_pkg::FLOOR_W-1:0]        out_noise_level
);

  localparam int EB = anfvg_pkg::ENERGY_BITS;

  logic [EB-1:0]                      ring_mem [anfvg_pkg::WINDOW];
  logic [EB-1:0]                      rd_data_r;
  logic                               rd_vld_r;
  logic [EB-1:0]                      e_r;
  logic [anfvg_pkg::VOTES_W-1:0]      votes_r;
  logic [EB-1:0]                      min_r;
  logic [EB-1:0]                      min_nxt;
  logic [anfvg_pkg::IDX_W-1:0]        wslot_r;
  logic [anfvg_pkg::CNT_W-1:0]        filled_r;
  logic [anfvg_pkg::IDX_W-1:0]        scan_r;
  logic [anfvg_pkg::CFG_W-1:0]        min_energy_r;
  logic [anfvg_pkg::FLOOR_W-1:0]      floor_r;
  logic [anfvg_pkg::FLOOR_W-1:0]      floor_nxt;
  logic [anfvg_pkg::PROD_W-1:0]       prod_r;
  logic [anfvg_pkg::MNEW_W-1:0]       mnew_r;
  logic [anfvg_pkg::PROD_W-1:0]       rnd;
  logic [anfvg_pkg::SUM_W-1:0]        sum;
  logic [anfvg_pkg::CMP_W-1:0]        thr_floor;
  logic [anfvg_pkg::CMP_W-1:0]        thr_cfg;
  logic [anfvg_pkg::CMP_W-1:0]        thr;
  logic [anfvg_pkg::CMP_W-1:0]        e_scaled;
  logic                               voice_nxt;
  logic                               out_valid_r;
  logic                               out_voice_r;
  logic [anfvg_pkg::FLOOR_W-1:0]      out_level_r;

  // Status back to the controller.
  assign sts.scan_last = (anfvg_pkg::CNT_W'(scan_r) + anfvg_pkg::CNT_W'(1) == filled_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Capture the accepted item; the energy is kept at its full width.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      e_r     <= EB'(in_frame_energy);
      votes_r <= in_speech_votes;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_energy_r <= '0;
    end else if (cfg_valid) begin
      min_energy_r <= cfg_data;
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.ring_wr) begin
      ring_mem[wslot_r] <= e_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= ring_mem[scan_r];
    end
  end

  // Write slot, fill count and scan address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r  <= '0;
      filled_r <= '0;
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.ring_wr) begin
        wslot_r <= (wslot_r == anfvg_pkg::IDX_W'(anfvg_pkg::WINDOW - 1))
                   ? '0 : wslot_r + anfvg_pkg::IDX_W'(1);
        if (filled_r != anfvg_pkg::CNT_W'(anfvg_pkg::WINDOW)) begin
          filled_r <= filled_r + anfvg_pkg::CNT_W'(1);
        end
      end
      if (cmd.cap) begin
        scan_r <= '0;
      end else if (cmd.rd_en) begin
        scan_r <= scan_r + anfvg_pkg::IDX_W'(1);
      end
    end
  end

  // Running minimum: starts at the new energy, folds in each read entry.
  always_comb begin
    min_nxt = min_r;
    if (cmd.ring_wr) begin
      min_nxt = e_r;
    end else if (rd_vld_r && (rd_data_r < min_r)) begin
      min_nxt = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
  end

  // Weighted products, registered before the sum.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= anfvg_pkg::PROD_W'(floor_r) * anfvg_pkg::PROD_W'(anfvg_pkg::OLD_WEIGHT);
      mnew_r <= anfvg_pkg::MNEW_W'(min_r) * anfvg_pkg::MNEW_W'(anfvg_pkg::NEW_WEIGHT);
    end
  end

  // Floor update: load on the first frame, else round the old term and add.
  always_comb begin
    rnd = prod_r + anfvg_pkg::PROD_W'(anfvg_pkg::ROUND_HALF);
    if (filled_r == anfvg_pkg::CNT_W'(1)) begin
      sum = anfvg_pkg::SUM_W'({min_r, {anfvg_pkg::FRAC_W{1'b0}}});
    end else begin
      sum = anfvg_pkg::SUM_W'(rnd[anfvg_pkg::PROD_W-1:anfvg_pkg::FRAC_W])
          + anfvg_pkg::SUM_W'(mnew_r);
    end
    if (sum > anfvg_pkg::SUM_W'({anfvg_pkg::FLOOR_W{1'b1}})) begin
      floor_nxt = '1;
    end else begin
      floor_nxt = anfvg_pkg::FLOOR_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
    end else if (cmd.upd) begin
      floor_r <= floor_nxt;
    end
  end

  // Threshold and voice decision.
  always_comb begin
    thr_floor = anfvg_pkg::CMP_W'({floor_r, 1'b0});
    thr_cfg   = anfvg_pkg::CMP_W'({min_energy_r, {anfvg_pkg::FRAC_W{1'b0}}});
    thr       = (thr_floor < thr_cfg) ? thr_cfg : thr_floor;
    e_scaled  = anfvg_pkg::CMP_W'({e_r, {anfvg_pkg::FRAC_W{1'b0}}});
    voice_nxt = (votes_r >= anfvg_pkg::VOTE_MIN) && (e_scaled > thr);
  end

  // Result register; a transfer frees it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_voice_r <= voice_nxt;
      out_level_r <= floor_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_voice       = out_voice_r;
  assign out_noise_level = out_level_r;

  // Checks.
  `ANFVG_ASSERT(a_load_when_free, cmd.out_load |-> sts.out_free, "result load over a pending result")
  `ANFVG_ASSERT(a_valid_from_load, $rose(out_valid_r) |-> $past(cmd.out_load), "result valid without a load")
  `ANFVG_ASSERT(a_min_bounded, cmd.upd |-> !(min_r > e_r), "minimum above the new energy")
  `ANFVG_ASSERT(a_fill_bounded, !(filled_r > anfvg_pkg::CNT_W'(anfvg_pkg::WINDOW)), "fill count above window")
  `ANFVG_ASSERT_ALWAYS(a_reset_drops_valid, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
